/* rtl/tlr_pkg.sv */
// Shared types and constants for the tensor layout reformatter.
package tlr_pkg;

    // Fixed field widths.
    localparam int ADDR_W     = 34;
    localparam int VALUE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Pad count of one run; covers slice depths up to 128.
    localparam int PAD_W = 7;

    // Batch count limit and position width.
    localparam int MAX_BATCH = 16;
    localparam int BATCH_W   = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN  = 3'd5;

    // Transform modes.
    typedef enum logic [1:0] {
        MODE_SLICE   = 2'd0,
        MODE_PLANAR  = 2'd1,
        MODE_UNSLICE = 2'd2,
        MODE_NONE    = 2'd3
    } t_mode;

    // One run of destination writes: a data write followed by pad_cnt pad writes
    // at consecutive addresses.
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic [PAD_W-1:0]   pad_cnt;
        logic               done;
    } t_run;

endpackage

/* rtl/tlr_front.sv */
// Front end: configuration registers, source position counters and run builder.
module tlr_front #(
    parameter int SLICE_DEPTH = 32,
    parameter int MAX_DIM     = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tlr_pkg::VALUE_W-1:0]     i_in_value,
    input  logic                            i_cfg_we,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_full,
    output logic                            o_push,
    output tlr_pkg::t_run                   o_run,
    output logic [tlr_pkg::VALUE_W-1:0]     o_pad_value
);

    localparam int SD_LOG = $clog2(SLICE_DEPTH);
    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CH_W   = $clog2(MAX_DIM + SLICE_DEPTH);
    localparam int WSD_W  = DIM_W + SD_LOG;
    localparam int HOW_W  = DIM_W + CH_W;
    localparam int TMP_W  = (DIM_W > tlr_pkg::CFG_DATA_W) ? DIM_W : tlr_pkg::CFG_DATA_W;
    localparam int AW     = tlr_pkg::ADDR_W;
    localparam int PW     = tlr_pkg::PAD_W;
    localparam int BW     = tlr_pkg::BATCH_W;

    // A zero count is used as one, an oversized count as the maximum.
    function automatic logic [DIM_W-1:0] dim_use(input logic [tlr_pkg::CFG_DATA_W-1:0] v);
        logic [TMP_W-1:0] t;
        t = TMP_W'(v);
        if (t == '0) begin
            dim_use = DIM_W'(1);
        end else if (t > TMP_W'(MAX_DIM)) begin
            dim_use = DIM_W'(MAX_DIM);
        end else begin
            dim_use = DIM_W'(t);
        end
    endfunction

    // Configuration and derived strides.
    tlr_pkg::t_mode               r_mode;
    logic [tlr_pkg::VALUE_W-1:0]  r_pad;
    logic [BW-1:0]                r_bm1;
    logic [POS_W-1:0]             r_hm1;
    logic [POS_W-1:0]             r_wm1;
    logic [POS_W-1:0]             r_cm1;
    logic [DIM_W-1:0]             r_cc;
    logic [WSD_W-1:0]             r_wsd;
    logic [CH_W-1:0]              r_ow;
    logic [PW-1:0]                r_padw;
    logic [PW:0]                  r_gap;
    logic [HOW_W-1:0]             r_how;

    // Source positions and address trackers.
    logic [BW-1:0]    r_b, n_b;
    logic [POS_W-1:0] r_h, n_h;
    logic [POS_W-1:0] r_w, n_w;
    logic [CH_W-1:0]  r_c, n_c;
    logic [AW-1:0]    r_pa, n_pa;
    logic [AW-1:0]    r_pb, n_pb;
    logic [AW-1:0]    r_rc, n_rc;

    logic                 accept;
    logic                 cfg_hit;
    logic [DIM_W-1:0]     dim_v;
    logic [CH_W-1:0]      ow_v;
    logic [4:0]           batch_raw;
    logic [BW-1:0]        batch_m1;
    logic [DIM_W-1:0]     mul_h;
    logic [CH_W-1:0]      mul_ow;
    logic [HOW_W-1:0]     how_v;
    logic                 last_b, last_h, last_w, last_c, last_img;
    logic [SD_LOG-1:0]    lane;
    logic                 lane_last;
    logic                 c_real;
    logic                 more_slices;
    logic                 wr;

    assign o_in_ready  = !i_full;
    assign accept      = i_in_valid && !i_full;
    assign o_pad_value = r_pad;
    assign cfg_hit     = i_cfg_we && (i_cfg_idx <= tlr_pkg::CFG_CHAN);

    // Values derived from the write data at the moment of a configuration write.
    always_comb begin
        dim_v     = dim_use(i_cfg_data);
        ow_v      = ((CH_W'(dim_v) + CH_W'(SLICE_DEPTH - 1)) >> SD_LOG) << SD_LOG;
        batch_raw = i_cfg_data[4:0];
        if (batch_raw == 5'd0) begin
            batch_m1 = '0;
        end else if (batch_raw > 5'(tlr_pkg::MAX_BATCH)) begin
            batch_m1 = BW'(tlr_pkg::MAX_BATCH - 1);
        end else begin
            batch_m1 = BW'(batch_raw - 5'd1);
        end
        if (i_cfg_idx == tlr_pkg::CFG_ROW) begin
            mul_h  = dim_v;
            mul_ow = r_ow;
        end else begin
            mul_h  = DIM_W'(r_hm1) + DIM_W'(1);
            mul_ow = ow_v;
        end
        how_v = HOW_W'(mul_h) * HOW_W'(mul_ow);
    end

    // Position flags.
    always_comb begin
        last_b      = (r_b == r_bm1);
        last_h      = (r_h == r_hm1);
        last_w      = (r_w == r_wm1);
        last_c      = (r_c == CH_W'(r_cm1));
        last_img    = last_b && last_h;
        lane        = r_c[SD_LOG-1:0];
        lane_last   = &lane;
        c_real      = (r_c <= CH_W'(r_cm1));
        more_slices = ({1'b0, r_c} + (CH_W + 1)'(1)) < (CH_W + 1)'(r_cc);
    end

    // Run for the current byte.
    always_comb begin
        o_run.value   = i_in_value;
        o_run.done    = last_img && last_w && last_c;
        o_run.addr    = r_pa;
        o_run.pad_cnt = '0;
        wr            = 1'b0;
        unique case (r_mode)
            tlr_pkg::MODE_SLICE: begin
                wr         = 1'b1;
                o_run.addr = r_pa + AW'(lane);
                if (last_c) begin
                    o_run.pad_cnt = PW'(SLICE_DEPTH - 1) - PW'(lane);
                end
            end
            tlr_pkg::MODE_PLANAR: begin
                wr         = 1'b1;
                o_run.addr = r_pa + r_rc;
                if (last_w) begin
                    o_run.pad_cnt = r_padw;
                end
            end
            tlr_pkg::MODE_UNSLICE: begin
                wr         = c_real;
                o_run.addr = r_pa + AW'(r_c);
            end
            tlr_pkg::MODE_NONE: begin
                wr = 1'b0;
            end
        endcase
    end

    assign o_push = accept && wr;

    // Position advance.
    always_comb begin
        n_b  = r_b;
        n_h  = r_h;
        n_w  = r_w;
        n_c  = r_c;
        n_pa = r_pa;
        n_pb = r_pb;
        n_rc = r_rc;
        unique case (r_mode) inside
            tlr_pkg::MODE_SLICE, tlr_pkg::MODE_PLANAR: begin
                if (!last_c) begin
                    n_c = r_c + CH_W'(1);
                    if (r_mode == tlr_pkg::MODE_PLANAR) begin
                        n_pa = r_pa + AW'(r_how);
                    end else if (lane_last) begin
                        n_pa = r_pa + AW'(r_wsd);
                    end
                end else if (!last_w) begin
                    n_c = '0;
                    n_w = r_w + POS_W'(1);
                    if (r_mode == tlr_pkg::MODE_SLICE) begin
                        n_pb = r_pb + AW'(SLICE_DEPTH);
                        n_pa = r_pb + AW'(SLICE_DEPTH);
                    end else begin
                        n_pa = r_pb;
                        n_rc = r_rc + AW'(1);
                    end
                end else if (!last_img) begin
                    n_c = '0;
                    n_w = '0;
                    if (!last_h) begin
                        n_h = r_h + POS_W'(1);
                    end else begin
                        n_h = '0;
                        n_b = r_b + BW'(1);
                    end
                    if (r_mode == tlr_pkg::MODE_SLICE) begin
                        // The next row starts right after the last slice of this one.
                        n_pb = r_pa + AW'(SLICE_DEPTH);
                        n_pa = r_pa + AW'(SLICE_DEPTH);
                    end else if (!last_h) begin
                        n_pa = r_pb;
                        n_rc = r_rc + AW'(r_gap);
                    end else begin
                        // The next image starts after the last channel plane.
                        n_pb = r_pa + AW'(r_how);
                        n_pa = r_pa + AW'(r_how);
                        n_rc = '0;
                    end
                end else begin
                    n_b  = '0;
                    n_h  = '0;
                    n_w  = '0;
                    n_c  = '0;
                    n_pa = '0;
                    n_pb = '0;
                    n_rc = '0;
                end
            end
            tlr_pkg::MODE_UNSLICE: begin
                if (!lane_last) begin
                    n_c = r_c + CH_W'(1);
                end else if (!last_w) begin
                    n_c  = r_c & ~CH_W'(SLICE_DEPTH - 1);
                    n_w  = r_w + POS_W'(1);
                    n_pa = r_pa + AW'(r_cc);
                end else if (more_slices) begin
                    n_c  = r_c + CH_W'(1);
                    n_w  = '0;
                    n_pa = r_pb;
                end else if (!last_img) begin
                    n_c = '0;
                    n_w = '0;
                    if (!last_h) begin
                        n_h = r_h + POS_W'(1);
                    end else begin
                        n_h = '0;
                        n_b = r_b + BW'(1);
                    end
                    n_pb = r_pa + AW'(r_cc);
                    n_pa = r_pa + AW'(r_cc);
                end else begin
                    n_b  = '0;
                    n_h  = '0;
                    n_w  = '0;
                    n_c  = '0;
                    n_pa = '0;
                    n_pb = '0;
                    n_rc = '0;
                end
            end
            default: begin
                n_c = r_c;
            end
        endcase
    end

    // Configuration writes and position registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tlr_pkg::MODE_SLICE;
            r_pad  <= '0;
            r_bm1  <= '0;
            r_hm1  <= '0;
            r_wm1  <= '0;
            r_cm1  <= '0;
            r_cc   <= DIM_W'(1);
            r_wsd  <= WSD_W'(SLICE_DEPTH);
            r_ow   <= CH_W'(SLICE_DEPTH);
            r_padw <= PW'(SLICE_DEPTH - 1);
            r_gap  <= (PW + 1)'(SLICE_DEPTH);
            r_how  <= HOW_W'(SLICE_DEPTH);
            r_b    <= '0;
            r_h    <= '0;
            r_w    <= '0;
            r_c    <= '0;
            r_pa   <= '0;
            r_pb   <= '0;
            r_rc   <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_idx)
                tlr_pkg::CFG_MODE: begin
                    r_mode <= tlr_pkg::t_mode'(i_cfg_data[1:0]);
                end
                tlr_pkg::CFG_PAD: begin
                    r_pad <= i_cfg_data[tlr_pkg::VALUE_W-1:0];
                end
                tlr_pkg::CFG_BATCH: begin
                    r_bm1 <= batch_m1;
                end
                tlr_pkg::CFG_ROW: begin
                    r_hm1 <= POS_W'(dim_v - DIM_W'(1));
                    r_how <= how_v;
                end
                tlr_pkg::CFG_COL: begin
                    r_wm1  <= POS_W'(dim_v - DIM_W'(1));
                    r_wsd  <= {dim_v, SD_LOG'(0)};
                    r_ow   <= ow_v;
                    r_padw <= PW'(ow_v - CH_W'(dim_v));
                    r_gap  <= (PW + 1)'(ow_v - CH_W'(dim_v)) + (PW + 1)'(1);
                    r_how  <= how_v;
                end
                tlr_pkg::CFG_CHAN: begin
                    r_cm1 <= POS_W'(dim_v - DIM_W'(1));
                    r_cc  <= dim_v;
                end
                default: begin
                    r_pad <= r_pad;
                end
            endcase
            // Any register write starts a new tensor.
            r_b  <= '0;
            r_h  <= '0;
            r_w  <= '0;
            r_c  <= '0;
            r_pa <= '0;
            r_pb <= '0;
            r_rc <= '0;
        end else if (accept) begin
            r_b  <= n_b;
            r_h  <= n_h;
            r_w  <= n_w;
            r_c  <= n_c;
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_rc <= n_rc;
        end
    end

`ifndef NO_ASSERTIONS
    // A register write returns every position counter to the tensor start.
    a_cfg_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_hit |=> (r_b == '0) && (r_h == '0) && (r_w == '0) && (r_c == '0))
        else $error("position counters not cleared after a configuration write");
`endif

endmodule

/* rtl/tlr_queue.sv */
// Short run queue between the front end and the write generator.
module tlr_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tlr_pkg::t_run i_data,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output tlr_pkg::t_run o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tlr_pkg::t_run    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    // The front end never offers a run while the queue is full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("run pushed into a full queue");

    // A lone push grows the fill count by one.
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("queue fill count did not follow a push");
`endif

endmodule

/* rtl/tlr_back.sv */
// Back end: expands each run into destination writes behind an output register.
module tlr_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  tlr_pkg::t_run                 i_q_data,
    output logic                          o_pop,
    input  logic [tlr_pkg::VALUE_W-1:0]   i_pad_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [tlr_pkg::ADDR_W-1:0]    o_out_addr,
    output logic [tlr_pkg::VALUE_W-1:0]   o_out_value,
    output logic                          o_last_of_run,
    output logic                          o_tensor_done
);

    localparam int AW = tlr_pkg::ADDR_W;
    localparam int PW = tlr_pkg::PAD_W;

    // Output register.
    logic                         r_out_valid;
    logic [AW-1:0]                r_out_addr;
    logic [tlr_pkg::VALUE_W-1:0]  r_out_value;
    logic                         r_out_last;
    logic                         r_out_done;

    // Pad run in progress.
    logic          r_act;
    logic [AW-1:0] r_addr;
    logic [PW-1:0] r_left;
    logic          r_done;

    logic out_free;

    assign out_free      = !r_out_valid || i_out_ready;
    assign o_pop         = out_free && !r_act && i_q_valid;
    assign o_out_valid   = r_out_valid;
    assign o_out_addr    = r_out_addr;
    assign o_out_value   = r_out_value;
    assign o_last_of_run = r_out_last;
    assign o_tensor_done = r_out_done;

    // Control: output valid and the pad run tracker.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_act       <= 1'b0;
        end else if (out_free) begin
            if (r_act) begin
                r_out_valid <= 1'b1;
                if (r_left == '0) begin
                    r_act <= 1'b0;
                end
            end else if (i_q_valid) begin
                r_out_valid <= 1'b1;
                r_act       <= (i_q_data.pad_cnt != '0);
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: data write first, then pad writes at consecutive addresses.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_act) begin
                r_out_addr  <= r_addr;
                r_out_value <= i_pad_value;
                r_out_last  <= (r_left == '0);
                r_out_done  <= (r_left == '0) && r_done;
                r_addr      <= r_addr + AW'(1);
                r_left      <= r_left - PW'(1);
            end else if (i_q_valid) begin
                r_out_addr  <= i_q_data.addr;
                r_out_value <= i_q_data.value;
                r_out_last  <= (i_q_data.pad_cnt == '0);
                r_out_done  <= (i_q_data.pad_cnt == '0) && i_q_data.done;
                r_addr      <= i_q_data.addr + AW'(1);
                r_left      <= i_q_data.pad_cnt - PW'(1);
                r_done      <= i_q_data.done;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // While pad writes remain, the output register always holds a write.
    a_act_has_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> r_out_valid)
        else $error("pad run active with an empty output register");

    // The tensor end marker only rides on the final write of a run.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_last)
        else $error("tensor end marked on a write that is not last of its run");
`endif

endmodule

/* rtl/tensor_layout_reformatter_top.sv */
// Top level of the tensor layout reformatter.
// Converts a byte stream between NHWC, depth-sliced and row-padded planar
// layouts, emitting one destination write (address and byte) per transaction
// on the output. The front end accepts one source byte per clock cycle while
// the run queue is not full and turns it into a run: one data write plus, at
// the end of a pixel (slice mode) or of a row (planar mode), up to
// SLICE_DEPTH-1 pad writes. The write generator issues one write per cycle
// while the output is ready; a QUEUE_DEPTH-entry run queue absorbs the
// difference in rate. Padding lanes of the unslice mode and bytes taken in the
// unused mode make no write. A run passes the queue and then the output
// register. Configuration registers must be written only while the block is
// idle; the block does not enforce this. Any write restarts the tensor
// position at zero. SLICE_DEPTH must be a power of two.
module tensor_layout_reformatter_top #(
    parameter int SLICE_DEPTH = 32,
    parameter int MAX_DIM     = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [tlr_pkg::VALUE_W-1:0]     i_in_value,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [tlr_pkg::ADDR_W-1:0]      o_out_addr,
    output logic [tlr_pkg::VALUE_W-1:0]     o_out_value,
    output logic                            o_last_of_run,
    output logic                            o_tensor_done,
    input  logic                            i_cfg_we,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tlr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                         push;
    logic                         full;
    logic                         q_valid;
    logic                         pop;
    tlr_pkg::t_run                run_in;
    tlr_pkg::t_run                run_out;
    logic [tlr_pkg::VALUE_W-1:0]  pad_value;

    // Front end: configuration, positions and run building.
    tlr_front #(
        .SLICE_DEPTH (SLICE_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_value  (i_in_value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_run       (run_in),
        .o_pad_value (pad_value)
    );

    // Run queue.
    tlr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (run_in),
        .o_full  (full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_data  (run_out)
    );

    // Write generator.
    tlr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_data      (run_out),
        .o_pop         (pop),
        .i_pad_value   (pad_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_addr    (o_out_addr),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run),
        .o_tensor_done (o_tensor_done)
    );

endmodule
